FILE: rtl/sorted_three_way_intersection_macros.svh
// assertion macros for the three-way intersection block
// expects clk and rst_n in the including module's scope
`ifndef SORTED_THREE_WAY_INTERSECTION_MACROS_SVH
`define SORTED_THREE_WAY_INTERSECTION_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked out of reset
`define STI_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sti assertion failed");

// next-cycle implication, checked out of reset
`define STI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sti assertion failed");

`else

`define STI_ASSERT_IMPLY(lbl, ante, cons)
`define STI_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: rtl/sti_pkg.sv
// shared types and constants for the three-way sorted intersection block
// no dependencies
package sti_pkg;

  localparam int DATA_W    = 32;
  localparam int DEPTH_DEF = 16;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_RUN  = 1'b1;

  localparam logic [1:0] LIST_A = 2'd0;
  localparam logic [1:0] LIST_B = 2'd1;
  localparam logic [1:0] LIST_C = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_COMP,
    S_DONE
  } state_t;

endpackage

FILE: rtl/sorted_three_way_intersection.sv
// top level of the three-way sorted intersection block
// depends on sti_pkg and sorted_three_way_intersection_macros.svh
//
//  channel | ports                                             | handshake
//  --------+---------------------------------------------------+----------------------
//  in      | in_command, in_list_select, in_value              | in_valid / in_ready
//  out     | out_common_value, out_is_last, out_none_found,    | out_valid / out_ready
//          | out_overflow                                      |
//
// a load beat is taken even while a result waits on out.
// a run repeats a merge step (list read in fetch, then compare and advance),
// then ends with a list read that finds a list used up and a closing done state,
// which waits for the out slot.
// the three list memories have one read port each, which sets the step pace.
// in_ready is low for the whole run; a stalled out holds the merge in compare.
// synchronous active-low reset clears counts, pointers and flags.
`include "sorted_three_way_intersection_macros.svh"

module sorted_three_way_intersection #(
  parameter int DEPTH = sti_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_command,
  input  logic [1:0]                        in_list_select,
  input  logic signed [sti_pkg::DATA_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [sti_pkg::DATA_W-1:0] out_common_value,
  output logic                              out_is_last,
  output logic                              out_none_found,
  output logic                              out_overflow
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DW = sti_pkg::DATA_W;

  sti_pkg::state_t state_r, state_nxt;

  logic signed [DW-1:0] mem_a [DEPTH];
  logic signed [DW-1:0] mem_b [DEPTH];
  logic signed [DW-1:0] mem_c [DEPTH];

  logic signed [DW-1:0] rd_a_r, rd_b_r, rd_c_r;

  logic [CW-1:0] cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt, cnt_c_r, cnt_c_nxt;
  logic [CW-1:0] ptr_a_r, ptr_a_nxt, ptr_b_r, ptr_b_nxt, ptr_c_r, ptr_c_nxt;
  logic          drop_r, drop_nxt;

  // pending value doubles as the last matched value, used to skip duplicates
  logic                 pend_v_r, pend_v_nxt;
  logic signed [DW-1:0] pend_val_r, pend_val_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic signed [DW-1:0] out_val_r, out_val_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_none_r, out_none_nxt;
  logic                 out_ovf_r, out_ovf_nxt;

  logic in_fire, load_fire, run_fire;
  logic out_free, walk_end;
  logic eq_ab, eq_ac, le_ab, le_ac, le_bc, match;
  logic ptrs_in_bound, run_cleared;

  assign in_ready  = (state_r == sti_pkg::S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign load_fire = in_fire && (in_command == sti_pkg::CMD_LOAD);
  assign run_fire  = in_fire && (in_command == sti_pkg::CMD_RUN);
  assign out_free  = !out_valid_r || out_ready;

  assign walk_end = (ptr_a_r >= cnt_a_r) || (ptr_b_r >= cnt_b_r) || (ptr_c_r >= cnt_c_r);

  // shared compare unit over the three registered heads
  assign eq_ab = (rd_a_r == rd_b_r);
  assign eq_ac = (rd_a_r == rd_c_r);
  assign le_ab = (rd_a_r <= rd_b_r);
  assign le_ac = (rd_a_r <= rd_c_r);
  assign le_bc = (rd_b_r <= rd_c_r);
  assign match = eq_ab && eq_ac && (!pend_v_r || (rd_a_r != pend_val_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sti_pkg::S_IDLE: begin
        if (run_fire) state_nxt = sti_pkg::S_FETCH;
      end
      sti_pkg::S_FETCH: begin
        state_nxt = walk_end ? sti_pkg::S_DONE : sti_pkg::S_COMP;
      end
      sti_pkg::S_COMP: begin
        // a match with a pending value needs the out slot
        if (!(match && pend_v_r) || out_free) state_nxt = sti_pkg::S_FETCH;
      end
      sti_pkg::S_DONE: begin
        if (out_free) state_nxt = sti_pkg::S_IDLE;
      end
      default: state_nxt = sti_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_a_nxt     = cnt_a_r;
    cnt_b_nxt     = cnt_b_r;
    cnt_c_nxt     = cnt_c_r;
    ptr_a_nxt     = ptr_a_r;
    ptr_b_nxt     = ptr_b_r;
    ptr_c_nxt     = ptr_c_r;
    drop_nxt      = drop_r;
    pend_v_nxt    = pend_v_r;
    pend_val_nxt  = pend_val_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_val_nxt   = out_val_r;
    out_last_nxt  = out_last_r;
    out_none_nxt  = out_none_r;
    out_ovf_nxt   = out_ovf_r;
    unique case (state_r)
      sti_pkg::S_IDLE: begin
        if (load_fire) begin
          priority case (in_list_select)
            sti_pkg::LIST_A: begin
              if (cnt_a_r < CW'(DEPTH)) cnt_a_nxt = cnt_a_r + 1'b1;
              else drop_nxt = 1'b1;
            end
            sti_pkg::LIST_B: begin
              if (cnt_b_r < CW'(DEPTH)) cnt_b_nxt = cnt_b_r + 1'b1;
              else drop_nxt = 1'b1;
            end
            sti_pkg::LIST_C: begin
              if (cnt_c_r < CW'(DEPTH)) cnt_c_nxt = cnt_c_r + 1'b1;
              else drop_nxt = 1'b1;
            end
            default: ;
          endcase
        end
        if (run_fire) begin
          pend_v_nxt = 1'b0;
        end
      end
      sti_pkg::S_FETCH: ;
      sti_pkg::S_COMP: begin
        if (match) begin
          if (!pend_v_r || out_free) begin
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_val_nxt   = pend_val_r;
              out_last_nxt  = 1'b0;
              out_none_nxt  = 1'b0;
              out_ovf_nxt   = drop_r;
            end
            pend_v_nxt   = 1'b1;
            pend_val_nxt = rd_a_r;
            ptr_a_nxt    = ptr_a_r + 1'b1;
            ptr_b_nxt    = ptr_b_r + 1'b1;
            ptr_c_nxt    = ptr_c_r + 1'b1;
          end
        end else begin
          // smallest head advances, ties to a then b
          priority if (le_ab && le_ac) ptr_a_nxt = ptr_a_r + 1'b1;
          else if (le_bc)              ptr_b_nxt = ptr_b_r + 1'b1;
          else                         ptr_c_nxt = ptr_c_r + 1'b1;
        end
      end
      sti_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = pend_v_r ? pend_val_r : '0;
          out_last_nxt  = 1'b1;
          out_none_nxt  = !pend_v_r;
          out_ovf_nxt   = drop_r;
          cnt_a_nxt     = '0;
          cnt_b_nxt     = '0;
          cnt_c_nxt     = '0;
          ptr_a_nxt     = '0;
          ptr_b_nxt     = '0;
          ptr_c_nxt     = '0;
          drop_nxt      = 1'b0;
          pend_v_nxt    = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sti_pkg::S_IDLE;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      cnt_c_r     <= '0;
      ptr_a_r     <= '0;
      ptr_b_r     <= '0;
      ptr_c_r     <= '0;
      drop_r      <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_a_r     <= cnt_a_nxt;
      cnt_b_r     <= cnt_b_nxt;
      cnt_c_r     <= cnt_c_nxt;
      ptr_a_r     <= ptr_a_nxt;
      ptr_b_r     <= ptr_b_nxt;
      ptr_c_r     <= ptr_c_nxt;
      drop_r      <= drop_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_val_r <= pend_val_nxt;
    out_val_r  <= out_val_nxt;
    out_last_r <= out_last_nxt;
    out_none_r <= out_none_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  // list memories: append at the count, read at the pointer
  always_ff @(posedge clk) begin
    if (load_fire && (in_list_select == sti_pkg::LIST_A) && (cnt_a_r < CW'(DEPTH))) begin
      mem_a[cnt_a_r[AW-1:0]] <= in_value;
    end
    if (state_r == sti_pkg::S_FETCH) begin
      rd_a_r <= mem_a[ptr_a_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (load_fire && (in_list_select == sti_pkg::LIST_B) && (cnt_b_r < CW'(DEPTH))) begin
      mem_b[cnt_b_r[AW-1:0]] <= in_value;
    end
    if (state_r == sti_pkg::S_FETCH) begin
      rd_b_r <= mem_b[ptr_b_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (load_fire && (in_list_select == sti_pkg::LIST_C) && (cnt_c_r < CW'(DEPTH))) begin
      mem_c[cnt_c_r[AW-1:0]] <= in_value;
    end
    if (state_r == sti_pkg::S_FETCH) begin
      rd_c_r <= mem_c[ptr_c_r[AW-1:0]];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_common_value = out_val_r;
  assign out_is_last      = out_last_r;
  assign out_none_found   = out_none_r;
  assign out_overflow     = out_ovf_r;

  assign ptrs_in_bound = (ptr_a_r <= cnt_a_r) && (ptr_b_r <= cnt_b_r) && (ptr_c_r <= cnt_c_r);
  assign run_cleared   = (cnt_a_r == '0) && !drop_r && out_valid_r && out_last_r;

  `STI_ASSERT_IMPLY(a_none_is_last, out_valid_r && out_none_r, out_last_r && (out_val_r == '0))
  `STI_ASSERT_IMPLY(a_ptr_bound, 1'b1, ptrs_in_bound)
  `STI_ASSERT_NEXT(a_run_starts, run_fire, state_r == sti_pkg::S_FETCH)
  `STI_ASSERT_NEXT(a_done_clears, (state_r == sti_pkg::S_DONE) && out_free, run_cleared)

endmodule
